@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker module of the angle filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk, switched off while rst is high.
`define CMAF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cmaf check failed");

// Concurrent check sampled on clk that also holds during reset.
`define CMAF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cmaf check failed");

`endif

@@ rtl/cmaf_pkg.sv @@
// Shared types, constants and the arctangent table of the circular mean angle filter.
`default_nettype none

package cmaf_pkg;

  // Window length in samples, 2 to 256.
  localparam int WINDOW = 32;
  localparam int SLOT_W = $clog2(WINDOW);

  localparam int ANGLE_W = 14;
  localparam int MEAN_W  = 15;
  localparam int Q15_W   = 16;
  localparam int TOTAL_W = 24;

  // CORDIC datapath: angles in 2^-32 turn, wide enough for gain and pre-rotation.
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = CORDIC_W'(64'h4000_0000);
  localparam logic signed [CORDIC_W-1:0] HALF_TURN    = CORDIC_W'(64'h8000_0000);
  localparam logic signed [CORDIC_W-1:0] START_X      = CORDIC_W'(64'd652032874);

  localparam logic signed [MEAN_W-1:0] MEAN_MAX = MEAN_W'(8192);
  localparam logic signed [MEAN_W-1:0] MEAN_MIN = -MEAN_W'(8192);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_ROUND,
    ST_ACCUM,
    ST_VSETUP,
    ST_VEC,
    ST_FINISH
  } cmaf_state_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2F9;
      5'd15:   a = 32'h0000_517C;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A2F;
      5'd19:   a = 32'h0000_0517;
      5'd20:   a = 32'h0000_028B;
      5'd21:   a = 32'h0000_0145;
      5'd22:   a = 32'h0000_00A2;
      5'd23:   a = 32'h0000_0051;
      default: a = 32'h0000_0000;
    endcase
    return $signed({{(CORDIC_W-32){1'b0}}, a});
  endfunction

endpackage

`default_nettype wire

@@ rtl/circular_mean_angle_filter.sv @@
// Top level of the circular mean angle filter: sequencer, shared CORDIC unit and sample ring.
`default_nettype none

// Moving circular mean of rotor angles. Each transfer on the angle channel
// carries a 14-bit angle code (16384 counts per turn). The block turns it into
// sine and cosine in Q1.15, stores both in a ring of WINDOW entries, keeps
// running sums of the window, and reports the atan2 of the two sums as a signed
// angle in 1/16384 turn (-8192 to 8192). The first WINDOW-1 samples after reset
// only fill the ring and give no result; from then on every sample gives one.
// Both sums at zero report an angle of zero. While the ring fills, a sample
// passes through the transfer, 24 rotation iterations, rounding to Q1.15 and
// the update of the ring and the sums. Once results are produced it then goes
// through the setup of the vectoring pass, 24 vectoring iterations and the
// hand-over of the result. When both sums are zero the vectoring iterations
// are skipped. The hand-over waits while the previous result has not been
// transferred yet. The single CORDIC add/shift unit performs one iteration per
// cycle and serves both the sine/cosine and the atan2 passes. The result sits
// in an output register, so a new sample is taken while the previous result
// still waits for its transfer. The ring needs no clearing after reset.
module circular_mean_angle_filter
  import cmaf_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [ANGLE_W-1:0]        raw_angle,
  input  wire logic                      angle_valid,
  output logic                           angle_ready,
  output logic signed [MEAN_W-1:0]       mean_angle,
  output logic                           mean_valid,
  input  wire logic                      mean_ready
);

  // Rounds a CORDIC coordinate (gain-compensated 2^30 scale) to Q1.15.
  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = (v + CORDIC_W'(16384)) >>> 15;
    if (r > CORDIC_W'(32767)) begin
      r = CORDIC_W'(32767);
    end else if (r < -CORDIC_W'(32767)) begin
      r = -CORDIC_W'(32767);
    end
    return r[Q15_W-1:0];
  endfunction

  cmaf_state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;

  logic signed [CORDIC_W-1:0] x, x_next;
  logic signed [CORDIC_W-1:0] y, y_next;
  logic signed [CORDIC_W-1:0] z, z_next;
  logic flip, flip_next;

  logic signed [Q15_W-1:0] sin_q, sin_q_next;
  logic signed [Q15_W-1:0] cos_q, cos_q_next;

  logic signed [TOTAL_W-1:0] sine_total, sine_total_next;
  logic signed [TOTAL_W-1:0] cosine_total, cosine_total_next;
  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic window_full, window_full_next;

  logic signed [MEAN_W-1:0] mean_angle_next;
  logic mean_valid_next;

  // Sample ring: sine in the upper half of an entry, cosine in the lower half.
  logic [2*Q15_W-1:0] ring [WINDOW];
  logic [2*Q15_W-1:0] ring_rd;
  logic               ring_we;

  // Shared CORDIC iteration.
  logic signed [CORDIC_W-1:0] x_sh, y_sh, atan_val;
  logic signed [CORDIC_W-1:0] x_it, y_it, z_it;
  logic                       ccw;

  logic signed [CORDIC_W-1:0] z_in, x_fin, y_fin, x_vec, y_vec, mean_wide;
  logic signed [Q15_W-1:0]    old_sin, old_cos;

  always_comb begin
    x_sh     = x >>> step;
    y_sh     = y >>> step;
    atan_val = atan_turn(step);
    // Rotation mode drives z to zero, vectoring mode drives y to zero.
    if (state == ST_ROT) begin
      ccw = !z[CORDIC_W-1];
    end else begin
      ccw = y[CORDIC_W-1] || (y == '0);
    end
    if (ccw) begin
      x_it = x - y_sh;
      y_it = y + x_sh;
      z_it = z - atan_val;
    end else begin
      x_it = x + y_sh;
      y_it = y - x_sh;
      z_it = z + atan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[write_slot] <= {sin_q, cos_q};
    end
    ring_rd <= ring[write_slot];
  end

  always_comb begin
    state_next        = state;
    step_next         = step;
    x_next            = x;
    y_next            = y;
    z_next            = z;
    flip_next         = flip;
    sin_q_next        = sin_q;
    cos_q_next        = cos_q;
    sine_total_next   = sine_total;
    cosine_total_next = cosine_total;
    write_slot_next   = write_slot;
    window_full_next  = window_full;
    mean_angle_next   = mean_angle;
    mean_valid_next   = mean_valid && !mean_ready;
    angle_ready       = 1'b0;
    ring_we           = 1'b0;

    // The code scaled to 2^-32 turn, read as a signed angle in half a turn either way.
    z_in      = $signed({{(CORDIC_W-32){raw_angle[ANGLE_W-1]}}, raw_angle, 18'b0});
    x_fin     = flip ? -x : x;
    y_fin     = flip ? -y : y;
    old_sin   = $signed(ring_rd[2*Q15_W-1:Q15_W]);
    old_cos   = $signed(ring_rd[Q15_W-1:0]);
    x_vec     = $signed({{(CORDIC_W-TOTAL_W-6){cosine_total[TOTAL_W-1]}}, cosine_total, 6'b0});
    y_vec     = $signed({{(CORDIC_W-TOTAL_W-6){sine_total[TOTAL_W-1]}}, sine_total, 6'b0});
    mean_wide = (z + CORDIC_W'(131072)) >>> 18;

    case (state)
      ST_IDLE: begin
        angle_ready = 1'b1;
        if (angle_valid) begin
          // Fold into the right half plane; the half-turn shift is undone by
          // negating both results.
          x_next    = START_X;
          y_next    = '0;
          step_next = '0;
          if (z_in > QUARTER_TURN) begin
            z_next    = z_in - HALF_TURN;
            flip_next = 1'b1;
          end else if (z_in < -QUARTER_TURN) begin
            z_next    = z_in + HALF_TURN;
            flip_next = 1'b1;
          end else begin
            z_next    = z_in;
            flip_next = 1'b0;
          end
          state_next = ST_ROT;
        end
      end

      ST_ROT, ST_VEC: begin
        x_next    = x_it;
        y_next    = y_it;
        z_next    = z_it;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          step_next  = '0;
          state_next = (state == ST_ROT) ? ST_ROUND : ST_FINISH;
        end
      end

      ST_ROUND: begin
        sin_q_next = to_q15(y_fin);
        cos_q_next = to_q15(x_fin);
        state_next = ST_ACCUM;
      end

      ST_ACCUM: begin
        // The oldest sample leaves the sums only once the ring has wrapped.
        ring_we           = 1'b1;
        sine_total_next   = sine_total + TOTAL_W'(sin_q)
                            - (window_full ? TOTAL_W'(old_sin) : '0);
        cosine_total_next = cosine_total + TOTAL_W'(cos_q)
                            - (window_full ? TOTAL_W'(old_cos) : '0);
        if (write_slot == SLOT_W'(WINDOW - 1)) begin
          write_slot_next  = '0;
          window_full_next = 1'b1;
        end else begin
          write_slot_next = write_slot + SLOT_W'(1);
        end
        state_next = (window_full_next) ? ST_VSETUP : ST_IDLE;
      end

      ST_VSETUP: begin
        step_next = '0;
        if (sine_total == '0 && cosine_total == '0) begin
          // No direction at all: report zero.
          z_next     = '0;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_VEC;
          if (cosine_total[TOTAL_W-1]) begin
            // Left half plane: turn a quarter turn towards the positive x axis.
            if (!sine_total[TOTAL_W-1]) begin
              x_next = y_vec;
              y_next = -x_vec;
              z_next = QUARTER_TURN;
            end else begin
              x_next = -y_vec;
              y_next = x_vec;
              z_next = -QUARTER_TURN;
            end
          end else begin
            x_next = x_vec;
            y_next = y_vec;
            z_next = '0;
          end
        end
      end

      ST_FINISH: begin
        if (!mean_valid || mean_ready) begin
          if (mean_wide > CORDIC_W'(8192)) begin
            mean_angle_next = MEAN_MAX;
          end else if (mean_wide < -CORDIC_W'(8192)) begin
            mean_angle_next = MEAN_MIN;
          end else begin
            mean_angle_next = mean_wide[MEAN_W-1:0];
          end
          mean_valid_next = 1'b1;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      sine_total   <= '0;
      cosine_total <= '0;
      write_slot   <= '0;
      window_full  <= 1'b0;
      mean_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      sine_total   <= sine_total_next;
      cosine_total <= cosine_total_next;
      write_slot   <= write_slot_next;
      window_full  <= window_full_next;
      mean_valid   <= mean_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    x          <= x_next;
    y          <= y_next;
    z          <= z_next;
    flip       <= flip_next;
    sin_q      <= sin_q_next;
    cos_q      <= cos_q_next;
    mean_angle <= mean_angle_next;
  end

endmodule

`default_nettype wire

@@ rtl/cmaf_checker.sv @@
// Port-level checker of the circular mean angle filter and its bind.
`default_nettype none

`include "assert_macros.svh"

module cmaf_checker
  import cmaf_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic [ANGLE_W-1:0]       raw_angle,
  input wire logic                     angle_valid,
  input wire logic                     angle_ready,
  input wire logic signed [MEAN_W-1:0] mean_angle,
  input wire logic                     mean_valid,
  input wire logic                     mean_ready
);

  logic angle_xfer;
  assign angle_xfer = angle_valid && angle_ready;

  // A waiting result keeps its value until its transfer.
  `CMAF_ASSERT(a_mean_hold, mean_valid && !mean_ready |=> mean_valid && $stable(mean_angle))
  // A waiting sample keeps its value until its transfer.
  `CMAF_ASSERT(a_angle_hold, angle_valid && !angle_ready |=> angle_valid && $stable(raw_angle))
  // Every result lies within half a turn either way.
  `CMAF_ASSERT(a_mean_range, mean_valid |-> mean_angle <= MEAN_MAX && mean_angle >= MEAN_MIN)
  // The block works on one sample at a time.
  `CMAF_ASSERT(a_busy_after_xfer, angle_xfer |=> !angle_ready)
  // Nothing is offered on the result side right after reset.
  `CMAF_ASSERT_ALWAYS(a_reset_empty, rst |=> !mean_valid)

endmodule

bind circular_mean_angle_filter cmaf_checker u_cmaf_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the circular mean angle filter: directed table, random sweeps.
`timescale 1ns / 100ps

// The angle channel is fed from a directed table first and then from random
// segments. A bit-accurate predictor (rotation CORDIC for sine and cosine,
// window sums, vectoring CORDIC for atan2) runs on every accepted transfer
// and queues the expected mean. The mean channel is checked against the
// oldest queued value on every accepted transfer. Both channels idle at
// random, with stretches where they do not.
module testbench;
  import cmaf_pkg::*;

  localparam int CORDIC_N = 24;
  localparam longint TURN_QUARTER = 64'sd1073741824;
  localparam longint TURN_HALF = 64'sd2147483648;
  // Gain-compensated start value of the rotation CORDIC (2^30 times 1/K).
  localparam longint ROT_START_X = 64'sd652032874;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1200;

  // One row of the directed table: an angle sent count times in a row. When
  // typed is set, the mean of the last transfer of the row is the typed value.
  typedef struct {
    logic [ANGLE_W-1:0] angle;
    int count;
    bit typed;
    logic signed [MEAN_W-1:0] mean;
  } angle_row_t;

  localparam int ROWS = 19;

  logic clk;
  logic rst = 1'b1;
  logic [ANGLE_W-1:0] raw_angle = '0;
  logic angle_valid = 1'b0;
  logic angle_ready;
  logic signed [MEAN_W-1:0] mean_angle;
  logic mean_valid;
  logic mean_ready = 1'b0;

  // atan(2^-i) in units of 2^-32 turn.
  longint arctan_turns [CORDIC_N] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
    64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  // The first two rows fill the window with opposite angles, so both sums
  // cancel and the first mean is zero. Whole windows of one angle then give
  // the half turn, the quarter turns and zero exactly. The angle just past
  // the half turn lands on minus a half turn. The single angles after that
  // sit on both sides of every quarter boundary and at the top code.
  angle_row_t angle_rows [ROWS] = '{
    '{14'd0,     16, 1'b0, 15'sd0},
    '{14'd8192,  16, 1'b1, 15'sd0},
    '{14'd8192,  32, 1'b1, 15'sd8192},
    '{14'd8193,   1, 1'b0, 15'sd0},
    '{14'd4096,  32, 1'b1, 15'sd4096},
    '{14'd12288, 32, 1'b1, -15'sd4096},
    '{14'd0,     32, 1'b1, 15'sd0},
    '{14'd16383,  1, 1'b0, 15'sd0},
    '{14'd1,      1, 1'b0, 15'sd0},
    '{14'd8191,   1, 1'b0, 15'sd0},
    '{14'd4095,   1, 1'b0, 15'sd0},
    '{14'd4097,   1, 1'b0, 15'sd0},
    '{14'd12287,  1, 1'b0, 15'sd0},
    '{14'd12289,  1, 1'b0, 15'sd0},
    '{14'd2048,   1, 1'b0, 15'sd0},
    '{14'd6144,   1, 1'b0, 15'sd0},
    '{14'd10240,  1, 1'b0, 15'sd0},
    '{14'd14336,  1, 1'b0, 15'sd0},
    '{14'd16383,  1, 1'b0, 15'sd0}
  };

  // Predictor state: the two sample rings, their running sums, the next
  // ring slot and whether the window has been filled once.
  int sine_hist [WINDOW];
  int cosine_hist [WINDOW];
  int sine_acc = 0;
  int cosine_acc = 0;
  int ring_slot = 0;
  bit ring_filled = 1'b0;

  logic signed [MEAN_W-1:0] mean_expected [$];

  int mismatches = 0;
  int samples_sent = 0;
  int directed_sent = 0;
  int means_checked = 0;

  // When calm is set neither side idles.
  bit calm = 1'b0;
  int ready_left = 0;
  int ready_draw;

  circular_mean_angle_filter uut (
    .clk(clk),
    .rst(rst),
    .raw_angle(raw_angle),
    .angle_valid(angle_valid),
    .angle_ready(angle_ready),
    .mean_angle(mean_angle),
    .mean_valid(mean_valid),
    .mean_ready(mean_ready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Rounds a CORDIC coordinate (2^30 scale) to Q1.15 and keeps it symmetric.
  function automatic int q15_round(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return int'(r);
  endfunction

  // Sine and cosine of an angle code. The angle is folded into the right
  // half plane first; a fold by half a turn negates both coordinates.
  function automatic void angle_to_q15(input logic [ANGLE_W-1:0] code,
                                       output int sine_q, output int cosine_q);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit flip;
    z = longint'(code) << 18;
    x = ROT_START_X;
    y = 0;
    flip = 1'b0;
    if (z >= TURN_HALF) z -= 2 * TURN_HALF;
    if (z > TURN_QUARTER) begin
      z -= TURN_HALF;
      flip = 1'b1;
    end else if (z < -TURN_QUARTER) begin
      z += TURN_HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_turns[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_turns[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sine_q = q15_round(y);
    cosine_q = q15_round(x);
  endfunction

  // atan2 of the window sums in 1/16384 turn. A negative cosine sum is
  // turned a quarter turn toward the positive x axis before vectoring.
  function automatic logic signed [MEAN_W-1:0] mean_of_sums(input int sine_tot,
                                                            input int cosine_tot);
    longint x;
    longint y;
    longint z;
    longint t;
    longint r;
    if (sine_tot == 0 && cosine_tot == 0) return '0;
    x = longint'(cosine_tot) * 64;
    y = longint'(sine_tot) * 64;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x;
        x = y;
        y = -t;
        z = TURN_QUARTER;
      end else begin
        t = x;
        x = -y;
        y = t;
        z = -TURN_QUARTER;
      end
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      if (y > 0) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_turns[i];
      end else begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_turns[i];
      end
      x = t;
    end
    r = (z + 64'sd131072) >>> 18;
    if (r > 8192) r = 8192;
    if (r < -8192) r = -8192;
    return MEAN_W'(r);
  endfunction

  // Pushes one sample through the window. Returns whether it yields a mean.
  function automatic bit advance_window(input logic [ANGLE_W-1:0] code,
                                        output logic signed [MEAN_W-1:0] mean);
    int s;
    int c;
    angle_to_q15(code, s, c);
    if (ring_filled) begin
      sine_acc -= sine_hist[ring_slot];
      cosine_acc -= cosine_hist[ring_slot];
    end
    sine_acc += s;
    cosine_acc += c;
    sine_hist[ring_slot] = s;
    cosine_hist[ring_slot] = c;
    ring_slot++;
    if (ring_slot >= WINDOW) begin
      ring_slot = 0;
      ring_filled = 1'b1;
    end
    mean = ring_filled ? mean_of_sums(sine_acc, cosine_acc) : '0;
    return ring_filled;
  endfunction

  // Sends one angle. A gap lowers valid and puts junk on the payload; with no
  // gap valid stays high straight into the next transfer. On acceptance the
  // predictor runs and the expected mean, if any, is queued.
  task automatic send_angle(input logic [ANGLE_W-1:0] code, input bit typed,
                            input logic signed [MEAN_W-1:0] typed_mean);
    int gap;
    int draw;
    bit gives;
    logic signed [MEAN_W-1:0] predicted;
    draw = $urandom_range(0, 99);
    if (calm || draw < 55) gap = 0;
    else if (draw < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(15, 80);
    if (gap > 0) begin
      angle_valid <= 1'b0;
      raw_angle <= ANGLE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    raw_angle <= code;
    angle_valid <= 1'b1;
    do @(posedge clk); while (angle_ready !== 1'b1);
    gives = advance_window(code, predicted);
    if (gives) mean_expected.push_back(typed ? typed_mean : predicted);
    samples_sent++;
  endtask

  // Receiver: ready runs high for a while, or drops for a short or long stall.
  always @(posedge clk) begin
    if (rst) begin
      mean_ready <= 1'b0;
      ready_left <= 0;
    end else if (calm) begin
      mean_ready <= 1'b1;
      ready_left <= 0;
    end else if (ready_left == 0) begin
      ready_draw = $urandom_range(0, 99);
      if (ready_draw < 60) begin
        mean_ready <= 1'b1;
        ready_left <= $urandom_range(0, 8);
      end else if (ready_draw < 92) begin
        mean_ready <= 1'b0;
        ready_left <= $urandom_range(0, 3);
      end else begin
        mean_ready <= 1'b0;
        ready_left <= $urandom_range(15, 80);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // Every mean transfer is matched against the oldest expected mean.
  always @(posedge clk) begin
    if (!rst && mean_valid === 1'b1 && mean_ready === 1'b1) begin
      if (mean_expected.size() == 0) begin
        report_mismatch($sformatf("mean %0d with no sample pending", mean_angle));
      end else begin
        if (mean_angle !== mean_expected[0])
          report_mismatch($sformatf("mean_angle %0d, expected %0d", mean_angle,
                                    mean_expected[0]));
        void'(mean_expected.pop_front());
        means_checked++;
      end
    end
  end

  // Stimulus: reset, the directed table, then random segments, then drain.
  initial begin
    int kind;
    int seg_len;
    int center;
    int spread;
    int pos;
    int step;
    int offset;
    int random_sent;
    int waited;
    logic [ANGLE_W-1:0] code;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (angle_rows[r]) begin
      for (int k = 0; k < angle_rows[r].count; k++)
        send_angle(angle_rows[r].angle, angle_rows[r].typed && k == angle_rows[r].count - 1,
                   angle_rows[r].mean);
    end
    directed_sent = samples_sent;

    // Each segment draws one shape of rotor motion and one idling profile.
    // Clusters and sweeps look like a real rotor; opposite pairs drive the
    // sums close to zero and across the negative x axis; boundary samples
    // straddle the zero code; uniform codes are plain noise.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 4);
      seg_len = $urandom_range(20, 80);
      center = $urandom_range(0, 16383);
      spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 400);
      pos = center;
      step = $urandom_range(0, 1200) - 600;
      calm = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < seg_len; k++) begin
        offset = $urandom_range(0, 2 * spread) - spread;
        case (kind)
          0: code = ANGLE_W'($urandom_range(0, 16383));
          1: code = ANGLE_W'(center + offset);
          2: begin
            pos += step;
            code = ANGLE_W'(pos + offset / 8);
          end
          3: code = ANGLE_W'(center + ((k % 2) ? 8192 : 0) + offset / 16);
          default: code = ANGLE_W'(offset);
        endcase
        send_angle(code, 1'b0, '0);
        random_sent++;
      end
    end
    calm = 1'b0;
    angle_valid <= 1'b0;

    waited = 0;
    while (mean_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mean_expected.size() != 0)
      report_mismatch($sformatf("%0d expected means never arrived", mean_expected.size()));

    $display("covered %0d angle samples (%0d from the directed table, %0d random)",
             samples_sent, directed_sent, random_sent);
    $display("checked %0d means, %0d mismatches", means_checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run with the longest gaps and stalls.
  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
